FILE: hw/rtl/sfib_pkg.sv
package sfib_pkg;

    localparam int HOLD_SLOTS_DEF = 8;

    localparam int CNT_W    = 3;
    localparam int SIZE_W   = 32;
    localparam int SUM_W    = 35;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;

    localparam logic [STATUS_W-1:0] ST_PASS  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MIX   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INDEX = 3'd4;

    localparam logic [2:0]       MARKER_TAG = 3'b110;
    localparam logic [CNT_W-1:0] MAX_HELD   = 3'd7;

    typedef struct packed {
        logic indexed;
        logic hidden;
    } t_hdr_info;

    // bytes per size minus one, from floor(log2(v)) / 8
    function automatic logic [1:0] mag_of(input logic [SIZE_W-1:0] v);
        logic [1:0] m;
        if (v[31:24] != 8'd0) begin
            m = 2'd3;
        end else if (v[23:16] != 8'd0) begin
            m = 2'd2;
        end else if (v[15:8] != 8'd0) begin
            m = 2'd1;
        end else begin
            m = 2'd0;
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/superframe_index_builder_core.sv
// Channel  | Handshake           | Payload
// command  | i_start / o_busy    | i_cmd, i_frame_size, i_first_byte, i_last_byte,
//          |                     | i_index_lead_byte
// result   | o_valid (strobe)    | o_status, o_index_byte, o_frame_count,
//          |                     | o_total_size, o_last
//
// A transaction is taken when i_start is high and o_busy is low.
// Flush: no result. Descriptor with a single result: result registered in S_DECIDE.
// Index emission for n sizes of mag+1 bytes each: S_TOTAL, S_MARK, then per
// size one memory read (S_LOAD) and one byte out per cycle in S_BYTES, S_END.
// Reset (synchronous, i_rst_n low) empties the held set; the size store
// needs no clearing. Results are strobed for one cycle and cannot be stalled.
module superframe_index_builder_core #(
    parameter int HOLD_SLOTS = sfib_pkg::HOLD_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cmd,
    input  logic [sfib_pkg::SIZE_W-1:0]   i_frame_size,
    input  logic [7:0]                    i_first_byte,
    input  logic [7:0]                    i_last_byte,
    input  logic [7:0]                    i_index_lead_byte,
    output logic                          o_valid,
    output logic [sfib_pkg::STATUS_W-1:0] o_status,
    output logic [sfib_pkg::BYTE_W-1:0]   o_index_byte,
    output logic [sfib_pkg::CNT_W-1:0]    o_frame_count,
    output logic [sfib_pkg::SUM_W-1:0]    o_total_size,
    output logic                          o_last
);

    localparam int IDXW = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_TOTAL  = 7'b0000100,
        S_MARK   = 7'b0001000,
        S_LOAD   = 7'b0010000,
        S_BYTES  = 7'b0100000,
        S_END    = 7'b1000000
    } t_state;

    t_state                           r_state;
    logic [sfib_pkg::CNT_W-1:0]       r_held_cnt;
    logic [sfib_pkg::SIZE_W-1:0]      r_largest;
    logic [sfib_pkg::SUM_W-1:0]       r_size_sum;
    logic [sfib_pkg::SIZE_W-1:0]      r_held_mem [HOLD_SLOTS];
    logic [sfib_pkg::SIZE_W-1:0]      r_rd_data;
    logic [IDXW-1:0]                  r_rd_idx;

    logic [sfib_pkg::SIZE_W-1:0]      r_size;
    logic [7:0]                       r_first;
    logic [7:0]                       r_lastb;
    logic [7:0]                       r_lead;

    logic [1:0]                       r_mag;
    logic [1:0]                       r_byte_cnt;
    logic [sfib_pkg::CNT_W-1:0]       r_n;
    logic [sfib_pkg::SUM_W-1:0]       r_total;
    logic [7:0]                       r_marker;
    logic [sfib_pkg::SIZE_W-1:0]      r_shift;

    logic                             r_valid;
    logic [sfib_pkg::STATUS_W-1:0]    r_status;
    logic [sfib_pkg::BYTE_W-1:0]      r_byte;
    logic [sfib_pkg::CNT_W-1:0]       r_count;
    logic [sfib_pkg::SUM_W-1:0]       r_total_out;
    logic                             r_last;

    sfib_pkg::t_hdr_info              hdr;
    logic                             too_many;
    logic [1:0]                       mag_now;
    logic [5:0]                       idx_extra;
    logic [sfib_pkg::SUM_W-1:0]       add_b;
    logic [sfib_pkg::SUM_W-1:0]       add_sum;

    sfib_hdr_check u_hdr (
        .i_frame_size      (r_size),
        .i_first_byte      (r_first),
        .i_last_byte       (r_lastb),
        .i_index_lead_byte (r_lead),
        .o_info            (hdr)
    );

    assign too_many  = ({1'b0, r_held_cnt} + 4'd1 >= 4'(HOLD_SLOTS))
                    || (r_held_cnt >= sfib_pkg::MAX_HELD);
    assign mag_now   = sfib_pkg::mag_of(r_largest);
    assign idx_extra = 6'd2 + 6'({1'b0, mag_now} + 3'd1) * 6'(r_held_cnt);

    // shared adder: accumulate a held size, or add the index length
    assign add_b   = (r_state == S_TOTAL) ? 35'(idx_extra) : 35'(r_size);
    assign add_sum = r_size_sum + add_b;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && !(hdr.indexed && r_held_cnt != '0)
            && !((!hdr.hidden || hdr.indexed) && r_held_cnt == '0) && !too_many) begin
            r_held_mem[r_held_cnt[IDXW-1:0]] <= r_size;
        end
        r_rd_data <= r_held_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_held_cnt <= '0;
            r_largest  <= '0;
            r_size_sum <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_cmd) begin
                            r_held_cnt <= '0;
                            r_largest  <= '0;
                            r_size_sum <= '0;
                        end else begin
                            r_size  <= i_frame_size;
                            r_first <= i_first_byte;
                            r_lastb <= i_last_byte;
                            r_lead  <= i_index_lead_byte;
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_byte      <= '0;
                    r_count     <= '0;
                    r_total_out <= '0;
                    r_last      <= 1'b1;
                    r_state     <= S_IDLE;
                    if (hdr.indexed && r_held_cnt != '0) begin
                        r_valid  <= 1'b1;
                        r_status <= sfib_pkg::ST_MIX;
                    end else if ((!hdr.hidden || hdr.indexed) && r_held_cnt == '0) begin
                        r_valid  <= 1'b1;
                        r_status <= sfib_pkg::ST_PASS;
                    end else if (too_many) begin
                        r_valid  <= 1'b1;
                        r_status <= sfib_pkg::ST_FULL;
                    end else begin
                        r_held_cnt <= r_held_cnt + 3'd1;
                        r_size_sum <= add_sum;
                        if (r_size > r_largest) begin
                            r_largest <= r_size;
                        end
                        if (hdr.hidden) begin
                            r_valid  <= 1'b1;
                            r_status <= sfib_pkg::ST_HELD;
                        end else begin
                            r_state <= S_TOTAL;
                        end
                    end
                end
                S_TOTAL: begin
                    r_mag      <= mag_now;
                    r_n        <= r_held_cnt;
                    r_total    <= add_sum;
                    r_marker   <= {sfib_pkg::MARKER_TAG, mag_now, r_held_cnt - 3'd1};
                    r_rd_idx   <= '0;
                    r_held_cnt <= '0;
                    r_largest  <= '0;
                    r_size_sum <= '0;
                    r_state    <= S_MARK;
                end
                S_MARK: begin
                    r_valid     <= 1'b1;
                    r_status    <= sfib_pkg::ST_INDEX;
                    r_byte      <= r_marker;
                    r_count     <= r_n;
                    r_total_out <= r_total;
                    r_last      <= 1'b0;
                    r_state     <= S_LOAD;
                end
                S_LOAD: begin
                    r_shift    <= r_rd_data;
                    r_byte_cnt <= '0;
                    r_rd_idx   <= r_rd_idx + IDXW'(1);
                    r_state    <= S_BYTES;
                end
                S_BYTES: begin
                    r_valid     <= 1'b1;
                    r_status    <= sfib_pkg::ST_INDEX;
                    r_byte      <= r_shift[7:0];
                    r_count     <= r_n;
                    r_total_out <= r_total;
                    r_last      <= 1'b0;
                    r_shift     <= r_shift >> 8;
                    r_byte_cnt  <= r_byte_cnt + 2'd1;
                    if (r_byte_cnt == r_mag) begin
                        if (3'(r_rd_idx) == r_n) begin
                            r_state <= S_END;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_END: begin
                    r_valid     <= 1'b1;
                    r_status    <= sfib_pkg::ST_INDEX;
                    r_byte      <= r_marker;
                    r_count     <= r_n;
                    r_total_out <= r_total;
                    r_last      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_index_byte  = r_byte;
    assign o_frame_count = r_count;
    assign o_total_size  = r_total_out;
    assign o_last        = r_last;

endmodule

FILE: hw/rtl/sfib_hdr_check.sv
module sfib_hdr_check (
    input  logic [sfib_pkg::SIZE_W-1:0] i_frame_size,
    input  logic [7:0]                  i_first_byte,
    input  logic [7:0]                  i_last_byte,
    input  logic [7:0]                  i_index_lead_byte,
    output sfib_pkg::t_hdr_info         o_info
);

    logic [2:0] nbytes;
    logic [3:0] nfr;
    logic [5:0] idx_len;
    logic       profile3;
    logic       show_existing;
    logic       show_frame;

    assign nbytes  = 3'd1 + {1'b0, i_last_byte[4:3]};
    assign nfr     = 4'd1 + {1'b0, i_last_byte[2:0]};
    assign idx_len = 6'd2 + 6'(nfr) * 6'(nbytes);

    assign o_info.indexed = (i_last_byte[7:5] == sfib_pkg::MARKER_TAG)
                         && (i_frame_size != '0)
                         && (i_frame_size >= 32'(idx_len))
                         && (i_index_lead_byte == i_last_byte);

    // profile bits at 5 (low) and 4 (high); profile 3 adds a reserved bit
    assign profile3      = i_first_byte[5] & i_first_byte[4];
    assign show_existing = profile3 ? i_first_byte[2] : i_first_byte[3];
    assign show_frame    = profile3 ? i_first_byte[0] : i_first_byte[1];
    assign o_info.hidden = !show_existing && !show_frame;

endmodule

FILE: bench/superframe_index_builder_core_tb.sv
module superframe_index_builder_core_tb;

    localparam int SIZE_W   = sfib_pkg::SIZE_W;
    localparam int SUM_W    = sfib_pkg::SUM_W;
    localparam int CNT_W    = sfib_pkg::CNT_W;
    localparam int STATUS_W = sfib_pkg::STATUS_W;
    localparam int BYTE_W   = sfib_pkg::BYTE_W;

    localparam int HOLD        = sfib_pkg::HOLD_SLOTS_DEF;
    localparam int RAND_FRAMES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    typedef struct {
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [7:0]        hdr;
        logic [7:0]        tail_b;
        logic [7:0]        lead_b;
    } t_frame;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   ibyte;
        logic [CNT_W-1:0]    count;
        logic [SUM_W-1:0]    total;
        logic                is_last;
    } t_sf_result;

    class t_sf_index_tracker;
        logic [CNT_W-1:0]  held_cnt;
        logic [SIZE_W-1:0] held_sizes [8];
        logic [SIZE_W-1:0] largest;
        logic [SUM_W-1:0]  size_sum;
        t_sf_result        awaited_results [$];
        int mismatches;
        int n_trans, n_flush, n_pass, n_held, n_mix, n_full, n_index, n_ibytes;

        function new();
            drop_held();
        endfunction

        function void drop_held();
            held_cnt = '0;
            largest  = '0;
            size_sum = '0;
        endfunction

        function void await_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b,
                                   logic [CNT_W-1:0] c, logic [SUM_W-1:0] t, logic l);
            t_sf_result r;
            r.status  = st;
            r.ibyte   = b;
            r.count   = c;
            r.total   = t;
            r.is_last = l;
            awaited_results.push_back(r);
        endfunction

        function void take_frame(t_frame f);
            logic        indexed;
            logic        hidden;
            int unsigned need;
            int          sel;
            int          n;
            logic [1:0]  mag;
            logic [7:0]  marker;
            logic [SUM_W-1:0] total;
            indexed = 1'b0;
            n_trans++;
            if (f.cmd) begin
                n_flush++;
                drop_held();
                return;
            end
            if (f.tail_b[7:5] == sfib_pkg::MARKER_TAG && f.size != '0) begin
                need = 2 + (int'(f.tail_b[4:3]) + 1) * (int'(f.tail_b[2:0]) + 1);
                indexed = (f.size >= need) && (f.lead_b == f.tail_b);
            end
            // profile 3 carries one reserved bit before show_existing_frame
            sel = (f.hdr[5] && f.hdr[4]) ? 2 : 3;
            if (f.hdr[sel]) hidden = 1'b0;
            else hidden = !f.hdr[sel-2];

            if (indexed && held_cnt != '0) begin
                n_mix++;
                await_result(sfib_pkg::ST_MIX, '0, '0, '0, 1'b1);
                return;
            end
            if ((!hidden || indexed) && held_cnt == '0) begin
                n_pass++;
                await_result(sfib_pkg::ST_PASS, '0, '0, '0, 1'b1);
                return;
            end
            if (int'(held_cnt) + 1 >= HOLD || held_cnt >= sfib_pkg::MAX_HELD) begin
                n_full++;
                await_result(sfib_pkg::ST_FULL, '0, '0, '0, 1'b1);
                return;
            end
            held_sizes[held_cnt] = f.size;
            held_cnt = held_cnt + CNT_W'(1);
            if (f.size > largest) largest = f.size;
            size_sum = size_sum + SUM_W'(f.size);
            if (hidden) begin
                n_held++;
                await_result(sfib_pkg::ST_HELD, '0, '0, '0, 1'b1);
                return;
            end

            n = int'(held_cnt);
            if (largest >= 32'h0100_0000) mag = 2'd3;
            else if (largest >= 32'h0001_0000) mag = 2'd2;
            else if (largest >= 32'h0000_0100) mag = 2'd1;
            else mag = 2'd0;
            marker = {sfib_pkg::MARKER_TAG, mag, 3'(n - 1)};
            total = size_sum + SUM_W'(2) + SUM_W'((int'(mag) + 1) * n);
            n_index++;
            await_result(sfib_pkg::ST_INDEX, marker, held_cnt, total, 1'b0);
            for (int i = 0; i < n; i++) begin
                for (int b = 0; b <= int'(mag); b++) begin
                    await_result(sfib_pkg::ST_INDEX, 8'(held_sizes[i] >> (8 * b)),
                                 held_cnt, total, 1'b0);
                end
            end
            await_result(sfib_pkg::ST_INDEX, marker, held_cnt, total, 1'b1);
            drop_held();
        endfunction

        function void compare_result(t_sf_result got);
            t_sf_result want;
            if (got.status == sfib_pkg::ST_INDEX) n_ibytes++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: status %0d byte %02h count %0d total %0d last %0b",
                             got.status, got.ibyte, got.count, got.total, got.is_last);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.ibyte !== want.ibyte ||
                got.count !== want.count || got.total !== want.total ||
                got.is_last !== want.is_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %02h %0d %0d %0b, got %0d %02h %0d %0d %0b",
                             want.status, want.ibyte, want.count, want.total, want.is_last,
                             got.status, got.ibyte, got.count, got.total, got.is_last);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic                i_cmd;
    logic [SIZE_W-1:0]   i_frame_size;
    logic [7:0]          i_first_byte;
    logic [7:0]          i_last_byte;
    logic [7:0]          i_index_lead_byte;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_index_byte;
    logic [CNT_W-1:0]    o_frame_count;
    logic [SUM_W-1:0]    o_total_size;
    logic                o_last;

    t_sf_index_tracker tracker = new();
    int idle_pct;
    int stall_cycles;

    superframe_index_builder_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_cmd            (i_cmd),
        .i_frame_size     (i_frame_size),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .i_index_lead_byte(i_index_lead_byte),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_index_byte     (o_index_byte),
        .o_frame_count    (o_frame_count),
        .o_total_size     (o_total_size),
        .o_last           (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            tracker.compare_result('{o_status, o_index_byte, o_frame_count, o_total_size, o_last});
    end

    always @(posedge i_clk) begin
        if ((i_start && o_busy === 1'b0) || o_valid === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(t_frame f);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_cmd             <= f.cmd;
        i_frame_size      <= f.size;
        i_first_byte      <= f.hdr;
        i_last_byte       <= f.tail_b;
        i_index_lead_byte <= f.lead_b;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        tracker.take_frame(f);
    endtask

    task automatic send_fields(logic cmd, logic [SIZE_W-1:0] size, logic [7:0] hdr,
                               logic [7:0] tail_b, logic [7:0] lead_b);
        send('{cmd, size, hdr, tail_b, lead_b});
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited_results.size() > 0);
    endtask

    function automatic logic [7:0] make_hdr(logic hidden, logic existing);
        logic [7:0] h;
        int sel;
        h = 8'($urandom);
        sel = (h[5] && h[4]) ? 2 : 3;
        if (existing) begin
            h[sel] = 1'b1;
        end else begin
            h[sel]   = 1'b0;
            h[sel-2] = !hidden;
        end
        return h;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size(int mag);
        case (mag)
            0:       return $urandom_range(1, 255);
            1:       return $urandom_range(256, 65535);
            2:       return $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
            default: return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    task automatic send_superframe(output int sent);
        int nh;
        int mg;
        nh = ($urandom_range(99) < 10) ? $urandom_range(7, 8) : $urandom_range(0, 6);
        mg = $urandom_range(0, 3);
        for (int i = 0; i < nh; i++) begin
            send_fields(1'b0, rand_size($urandom_range(0, mg)), make_hdr(1'b1, 1'b0),
                        8'($urandom), 8'($urandom));
        end
        send_fields(1'b0, rand_size($urandom_range(0, mg)),
                    make_hdr(1'b0, 1'($urandom)), 8'($urandom), 8'($urandom));
        sent = nh + 1;
    endtask

    task automatic send_indexed();
        logic [7:0]        tb;
        logic [7:0]        ld;
        logic [SIZE_W-1:0] sz;
        int unsigned       need;
        tb = {sfib_pkg::MARKER_TAG, 5'($urandom)};
        need = 2 + (int'(tb[4:3]) + 1) * (int'(tb[2:0]) + 1);
        case ($urandom_range(3))
            0:       sz = need - 1;
            1:       sz = need;
            default: sz = $urandom_range(need, 32'hFFFF_FFFF);
        endcase
        ld = tb;
        if ($urandom_range(9) == 0) ld = tb ^ (8'h01 << $urandom_range(7));
        send_fields(1'b0, sz, 8'($urandom), tb, ld);
    endtask

    initial begin
        int rand_sent;
        int k;
        int pick;
        logic [SIZE_W-1:0] sz;
        i_rst_n           <= 1'b0;
        i_start           <= 1'b0;
        i_cmd             <= 1'b0;
        i_frame_size      <= '0;
        i_first_byte      <= '0;
        i_last_byte       <= '0;
        i_index_lead_byte <= '0;
        idle_pct = 11;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each status, header variants, zero sizes, limits
        send_fields(1'b0, 32'd1, 8'b0000_1000, 8'h00, 8'h00);
        send_fields(1'b0, 32'd2, 8'b0011_0001, 8'h00, 8'h00);
        send_fields(1'b0, 32'd3, 8'b0000_0000, 8'hC0, 8'hC0);
        send_fields(1'b0, 32'd0, 8'b0000_0000, 8'hC0, 8'hC0);
        send_fields(1'b0, 32'd0, 8'b0010_0010, 8'hC0, 8'hC0);
        send_fields(1'b0, 32'd300, 8'b0001_0000, 8'h5A, 8'hA5);
        send_fields(1'b0, 32'd34, 8'b0000_1000, 8'hDF, 8'hDF);
        send_fields(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(1'b0, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF);
        repeat (6) send_fields(1'b0, 32'hFFFF_FFFF, 8'hC0, 8'h3F, 8'h00);
        send_fields(1'b0, 32'hFFFF_FFFF, 8'hC2, 8'hFF, 8'h00);
        for (int i = 1; i <= 7; i++) send_fields(1'b0, 32'(i), 8'h00, 8'h00, 8'h00);
        send_fields(1'b0, 32'd8, 8'h00, 8'h00, 8'h00);
        send_fields(1'b0, 32'd9, 8'h02, 8'h00, 8'h00);
        send_fields(1'b1, 32'd1, 8'h00, 8'h00, 8'h00);
        drain();

        rand_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
            while (rand_sent < (ph + 1) * RAND_FRAMES / 3) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_superframe(k);
                    rand_sent += k;
                end else if (pick < 80) begin
                    send_indexed();
                    rand_sent++;
                end else if (pick < 88) begin
                    send_fields(1'b1, 32'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                    rand_sent++;
                end else begin
                    sz = 32'($urandom);
                    if (sz == '0) sz = 32'd1;
                    send_fields(1'b0, sz, 8'($urandom), 8'($urandom), 8'($urandom));
                    rand_sent++;
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions (%0d flushes): %0d passthrough, %0d held, %0d mixing",
                 tracker.n_trans, tracker.n_flush, tracker.n_pass, tracker.n_held, tracker.n_mix);
        $display("%0d too many, %0d superframe indexes in %0d index bytes, %0d mismatches",
                 tracker.n_full, tracker.n_index, tracker.n_ibytes, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
